// ===== hdl/sle_pkg.sv =====
// Shared constants, codes and types for the sorted list engine.
// Used by sle_cell, sle_chain and sorted_list_engine_core; no dependencies.
package sle_pkg;

    localparam int DEPTH   = 16;
    localparam int VAL_W   = 32;
    localparam int MODE_W  = 2;
    localparam int POS_W   = 5;
    localparam int STAT_W  = 3;
    localparam int FPOS_W  = 5;
    localparam int OCNT_W  = 5;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int S_DATA_W = ((MODE_W + VAL_W + POS_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((STAT_W + FPOS_W + OCNT_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_DELETED  = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_BADPOS   = 3'd4,
        ST_FOUND    = 3'd5,
        ST_NOTFOUND = 3'd6
    } status_t;

    // Broadcast to every cell for one beat.
    typedef struct packed {
        logic             ins_en;
        logic             del_en;
        logic [VAL_W-1:0] val;
        logic [CMP_W-1:0] pos;
        logic [CNT_W-1:0] count;
    } cell_cmd_t;

    // Flip the sign bit so signed order compares as unsigned order.
    function automatic logic [VAL_W-1:0] order_key(input logic [VAL_W-1:0] v);
        order_key = {~v[VAL_W-1], v[VAL_W-2:0]};
    endfunction

endpackage

// ===== hdl/sle_cell.sv =====
// One slot of the sorted list: holds a value, compares it with the
// broadcast operand and shifts to or from its neighbors. Uses sle_pkg.
module sle_cell (
    input  logic                        aclk,
    input  sle_pkg::cell_cmd_t          cmd,
    input  logic [sle_pkg::CNT_W-1:0]   cell_idx,
    input  logic [sle_pkg::VAL_W-1:0]   left_val,
    input  logic                        left_after,
    input  logic                        left_lt,
    input  logic [sle_pkg::VAL_W-1:0]   right_val,
    output logic [sle_pkg::VAL_W-1:0]   val,
    output logic                        after,
    output logic                        lt,
    output logic                        first_hit
);

    logic [sle_pkg::VAL_W-1:0] val_reg;
    logic [sle_pkg::VAL_W-1:0] val_next;
    logic                      occupied;
    logic [sle_pkg::VAL_W-1:0] key_own;
    logic [sle_pkg::VAL_W-1:0] key_cmd;
    logic [sle_pkg::CMP_W-1:0] idx_plus1;

    assign key_own   = sle_pkg::order_key(val_reg);
    assign key_cmd   = sle_pkg::order_key(cmd.val);
    assign occupied  = cell_idx < cmd.count;
    assign after     = !occupied || (key_own > key_cmd);
    assign lt        = occupied && (key_own < key_cmd);
    assign first_hit = occupied && (val_reg == cmd.val) && left_lt;
    assign idx_plus1 = sle_pkg::CMP_W'(cell_idx) + sle_pkg::CMP_W'(1);
    assign val       = val_reg;

    always_comb begin
        val_next = val_reg;
        if (cmd.ins_en && after) begin
            // take the left neighbor, or the new value at the slot itself
            val_next = left_after ? left_val : cmd.val;
        end else if (cmd.del_en && (idx_plus1 >= cmd.pos)) begin
            val_next = right_val;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

// ===== hdl/sle_chain.sv =====
// Row of DEPTH sle_cell slots wired to their neighbors, plus the encoder
// that turns the one-hot first-match flags into a position. Uses sle_pkg.
module sle_chain (
    input  logic                         aclk,
    input  sle_pkg::cell_cmd_t           cmd,
    output logic                         found,
    output logic [sle_pkg::FPOS_W-1:0]   found_pos
);

    logic [sle_pkg::VAL_W-1:0] vals [sle_pkg::DEPTH];
    logic [sle_pkg::DEPTH-1:0] afters;
    logic [sle_pkg::DEPTH-1:0] lts;
    logic [sle_pkg::DEPTH-1:0] firsts;

    for (genvar k = 0; k < sle_pkg::DEPTH; k++) begin : g_cell
        logic [sle_pkg::VAL_W-1:0] lval;
        logic                      lafter;
        logic                      llt;
        logic [sle_pkg::VAL_W-1:0] rval;

        if (k == 0) begin : g_head
            assign lval   = cmd.val;
            assign lafter = 1'b0;
            assign llt    = 1'b1;
        end else begin : g_body
            assign lval   = vals[k-1];
            assign lafter = afters[k-1];
            assign llt    = lts[k-1];
        end

        if (k == sle_pkg::DEPTH - 1) begin : g_tail
            assign rval = vals[k];
        end else begin : g_mid
            assign rval = vals[k+1];
        end

        sle_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .cell_idx    (sle_pkg::CNT_W'(k)),
            .left_val    (lval),
            .left_after  (lafter),
            .left_lt     (llt),
            .right_val   (rval),
            .val         (vals[k]),
            .after       (afters[k]),
            .lt          (lts[k]),
            .first_hit   (firsts[k])
        );
    end

    // at most one flag is set, so an OR of the gated positions encodes it
    always_comb begin
        found_pos = '0;
        for (int k = 0; k < sle_pkg::DEPTH; k++) begin
            if (firsts[k]) begin
                found_pos = found_pos | sle_pkg::FPOS_W'(k + 1);
            end
        end
    end

    assign found = |firsts;

endmodule

// ===== hdl/sorted_list_engine_core.sv =====
// Top level of the sorted list engine: stream ports, operation decode,
// entry count and result register. Uses sle_pkg and sle_chain.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+------------------------------------
//  s_      | in  | s_tvalid/s_tready | mode, value, position (one op)
//  m_      | out | m_tvalid/m_tready | status, found_position, count
//
// For every operation the cell row compares all slots with the operand at
// once and shifts on the accepting edge; the result shows the next cycle.
// A new beat is taken whenever the output register is empty or draining.
// Reset (aresetn low, synchronous) empties the list and the output register;
// slot contents are not cleared, only slots below the count are ever used.
// A stall on m_ holds the result and backs up s_tready, nothing is dropped.
module sorted_list_engine_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [1:0] mode, [33:2] value, [38:34] position, rest zero
    input  logic [sle_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] status, [7:3] found_position, [12:8] count, rest zero
    output logic [sle_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int VAL_LO = sle_pkg::MODE_W;
    localparam int POS_LO = VAL_LO + sle_pkg::VAL_W;

    logic                          fire;
    sle_pkg::mode_t                in_mode;
    logic [sle_pkg::VAL_W-1:0]     in_value;
    logic [sle_pkg::POS_W-1:0]     in_pos;
    sle_pkg::cell_cmd_t            cmd;
    logic                          is_full;
    logic                          pos_ok;
    logic                          found;
    logic [sle_pkg::FPOS_W-1:0]    found_pos;

    logic                          m_valid_reg;
    sle_pkg::status_t              status_reg, status_next;
    logic [sle_pkg::FPOS_W-1:0]    fpos_reg, fpos_next;
    logic [sle_pkg::CNT_W-1:0]     count_reg, count_next;

    assign s_tready = !m_valid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;

    assign in_mode  = sle_pkg::mode_t'(s_tdata[sle_pkg::MODE_W-1:0]);
    assign in_value = s_tdata[VAL_LO +: sle_pkg::VAL_W];
    assign in_pos   = s_tdata[POS_LO +: sle_pkg::POS_W];

    assign is_full = count_reg == sle_pkg::CNT_W'(sle_pkg::DEPTH);
    assign pos_ok  = (sle_pkg::CMP_W'(in_pos) != '0)
                  && (sle_pkg::CMP_W'(in_pos) <= sle_pkg::CMP_W'(count_reg));

    // Broadcast the operand; shift enables only on a legal, accepted beat.
    always_comb begin
        cmd.val    = in_value;
        cmd.pos    = sle_pkg::CMP_W'(in_pos);
        cmd.count  = count_reg;
        cmd.ins_en = fire && (in_mode == sle_pkg::MODE_INSERT) && !is_full;
        cmd.del_en = fire && (in_mode == sle_pkg::MODE_DELETE)
                  && (count_reg != '0) && pos_ok;
    end

    sle_chain u_chain (
        .aclk      (aclk),
        .cmd       (cmd),
        .found     (found),
        .found_pos (found_pos)
    );

    // Decode the result of the beat.
    always_comb begin
        status_next = sle_pkg::ST_NOTFOUND;
        fpos_next   = '0;
        count_next  = count_reg;
        case (in_mode)
            sle_pkg::MODE_INSERT: begin
                if (is_full) begin
                    status_next = sle_pkg::ST_FULL;
                end else begin
                    status_next = sle_pkg::ST_INSERTED;
                    count_next  = count_reg + sle_pkg::CNT_W'(1);
                end
            end
            sle_pkg::MODE_DELETE: begin
                if (count_reg == '0) begin
                    status_next = sle_pkg::ST_EMPTY;
                end else if (!pos_ok) begin
                    status_next = sle_pkg::ST_BADPOS;
                end else begin
                    status_next = sle_pkg::ST_DELETED;
                    count_next  = count_reg - sle_pkg::CNT_W'(1);
                end
            end
            sle_pkg::MODE_SEARCH: begin
                if (found) begin
                    status_next = sle_pkg::ST_FOUND;
                    fpos_next   = found_pos;
                end
            end
            default: begin
                status_next = sle_pkg::ST_NOTFOUND;
            end
        endcase
    end

    // Control: valid flag and list count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            if (fire) begin
                m_valid_reg <= 1'b1;
                count_reg   <= count_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: load on every accepted beat, hold otherwise.
    always_ff @(posedge aclk) begin
        if (fire) begin
            status_reg <= status_next;
            fpos_reg   <= fpos_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = sle_pkg::M_DATA_W'({sle_pkg::OCNT_W'(count_reg), fpos_reg,
                                          status_reg});

    // The count never runs past the list depth.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= sle_pkg::CNT_W'(sle_pkg::DEPTH))
        else $error("entry count above depth");

    // An insert into a full list leaves the count alone.
    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_mode == sle_pkg::MODE_INSERT && is_full |=> $stable(count_reg))
        else $error("count moved on insert into full list");

    // Every accepted beat shows a result on the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid_reg)
        else $error("accepted beat gave no result");

    // A found result always carries a nonzero position, others carry zero.
    a_fpos_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((status_reg == sle_pkg::ST_FOUND) == (fpos_reg != '0)))
        else $error("found position does not match status");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for sorted_list_engine_core: directed table, then random
// insert/delete/search and unused-mode beats checked against a behavioral sorted-list model.
// Depends on sle_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module testbench;

    localparam int RAND_ITEMS  = 420;
    localparam int CALM_ITEMS  = 60;      // last random beats: no idling on either side
    localparam int CYCLE_LIMIT = 200000;

    typedef logic signed [sle_pkg::VAL_W-1:0] val_t;

    typedef struct {
        sle_pkg::status_t           status;
        logic [sle_pkg::FPOS_W-1:0] fpos;
        logic [sle_pkg::OCNT_W-1:0] count;
    } list_result_t;

    typedef struct {
        sle_pkg::mode_t            op;
        val_t                      val;
        logic [sle_pkg::POS_W-1:0] pos;
        bit                        pinned;    // result typed in below, not from the model
        list_result_t              res;
    } list_op_row_t;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [sle_pkg::S_DATA_W-1:0]  s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [sle_pkg::M_DATA_W-1:0]  m_tdata;

    val_t          sorted_q[$];      // model copy of the stored entries, ascending
    list_result_t  pending_results[$];
    list_op_row_t  op_table[$];
    bit            idling_on = 1'b1;
    bit            growing   = 1'b1;
    int            error_cnt = 0;
    int            cycle_cnt = 0;

    sorted_list_engine_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    // Model of one operation: update the sorted list and return the expected result.
    function automatic list_result_t apply_list_op(input sle_pkg::mode_t op, input val_t v,
                                                   input logic [sle_pkg::POS_W-1:0] pos);
        list_result_t r;
        int           slot;
        r.status = sle_pkg::ST_NOTFOUND;
        r.fpos   = '0;
        case (op)
            sle_pkg::MODE_INSERT: begin
                if (sorted_q.size() >= sle_pkg::DEPTH) begin
                    r.status = sle_pkg::ST_FULL;
                end else begin
                    // land after every entry not greater than the new value
                    slot = sorted_q.size();
                    for (int k = 0; k < sorted_q.size(); k++) begin
                        if (slot == sorted_q.size() && sorted_q[k] > v)
                            slot = k;
                    end
                    sorted_q.insert(slot, v);
                    r.status = sle_pkg::ST_INSERTED;
                end
            end
            sle_pkg::MODE_DELETE: begin
                if (sorted_q.size() == 0)
                    r.status = sle_pkg::ST_EMPTY;
                else if (pos == 0 || int'(pos) > sorted_q.size())
                    r.status = sle_pkg::ST_BADPOS;
                else begin
                    sorted_q.delete(int'(pos) - 1);
                    r.status = sle_pkg::ST_DELETED;
                end
            end
            sle_pkg::MODE_SEARCH: begin
                // lowest matching position wins on duplicates
                for (int k = sorted_q.size() - 1; k >= 0; k--) begin
                    if (sorted_q[k] == v) begin
                        r.status = sle_pkg::ST_FOUND;
                        r.fpos   = sle_pkg::FPOS_W'(k + 1);
                    end
                end
            end
            default: r.status = sle_pkg::ST_NOTFOUND;
        endcase
        r.count = sle_pkg::OCNT_W'(sorted_q.size());
        return r;
    endfunction

    function automatic void add_row(input sle_pkg::mode_t op, input val_t v, input int pos,
                                    input bit pinned,
                                    input sle_pkg::status_t st = sle_pkg::ST_NOTFOUND,
                                    input int fpos = 0, input int cnt = 0);
        list_op_row_t row;
        row.op         = op;
        row.val        = v;
        row.pos        = sle_pkg::POS_W'(pos);
        row.pinned     = pinned;
        row.res.status = st;
        row.res.fpos   = sle_pkg::FPOS_W'(fpos);
        row.res.count  = sle_pkg::OCNT_W'(cnt);
        op_table.push_back(row);
    endfunction

    function automatic val_t pick_value();
        val_t pool[8] = '{0, -1, 1, 32'sh8000_0000, 32'sh7FFF_FFFF, 7, -7, 1000};
        if ($urandom_range(0, 99) < 45)
            return pool[$urandom_range(0, 7)];
        return val_t'($urandom);
    endfunction

    // Swing the list between empty and full; ignored fields still get random bits.
    function automatic void pick_random_op(output sle_pkg::mode_t op, output val_t v,
                                           output logic [sle_pkg::POS_W-1:0] pos);
        int roll;
        int cnt;
        cnt = sorted_q.size();
        if (cnt == sle_pkg::DEPTH && $urandom_range(0, 2) == 0)
            growing = 1'b0;
        else if (cnt == 0 && $urandom_range(0, 2) == 0)
            growing = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            op = sle_pkg::MODE_UNUSED;
        else if (growing)
            op = (roll < 60) ? sle_pkg::MODE_INSERT :
                 (roll < 85) ? sle_pkg::MODE_SEARCH : sle_pkg::MODE_DELETE;
        else
            op = (roll < 55) ? sle_pkg::MODE_DELETE :
                 (roll < 85) ? sle_pkg::MODE_SEARCH : sle_pkg::MODE_INSERT;

        v   = pick_value();
        pos = sle_pkg::POS_W'($urandom_range(0, 31));
        if (op == sle_pkg::MODE_SEARCH && cnt > 0 && $urandom_range(0, 99) < 60)
            v = sorted_q[$urandom_range(0, cnt - 1)];
        if (op == sle_pkg::MODE_DELETE) begin
            v    = val_t'($urandom);
            roll = $urandom_range(0, 99);
            if (roll < 75 && cnt > 0)
                pos = sle_pkg::POS_W'($urandom_range(1, cnt));
            else if (roll < 85)
                pos = ($urandom_range(0, 1) == 0) ? '0 : sle_pkg::POS_W'(cnt + 1);
        end
    endfunction

    // Drive one beat, hold it until accepted, then record the expected result.
    task automatic send_list_op(input sle_pkg::mode_t op, input val_t v,
                                input logic [sle_pkg::POS_W-1:0] pos,
                                input bit pinned, input list_result_t pinned_res);
        list_result_t predicted;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sle_pkg::S_DATA_W'({pos, v, op});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = apply_list_op(op, v, pos);
        pending_results.push_back(pinned ? pinned_res : predicted);
    endtask

    // Result side: random stall bursts, long ready runs in between.
    initial begin
        forever begin
            if (idling_on && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // Compare every result beat with the oldest expectation.
    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                error_cnt++;
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[2:0] !== want.status) begin
                    error_cnt++;
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             m_tdata[2:0]);
                end
                if (m_tdata[7:3] !== want.fpos) begin
                    error_cnt++;
                    $display("%0t: found_position expected %0d actual %0d", $time, want.fpos,
                             m_tdata[7:3]);
                end
                if (m_tdata[12:8] !== want.count) begin
                    error_cnt++;
                    $display("%0t: count expected %0d actual %0d", $time, want.count,
                             m_tdata[12:8]);
                end
            end
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        sle_pkg::mode_t            op;
        val_t                      v;
        logic [sle_pkg::POS_W-1:0] pos;
        list_result_t              none;

        none.status = sle_pkg::ST_NOTFOUND;
        none.fpos   = '0;
        none.count  = '0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;

        // empty list corner cases
        add_row(sle_pkg::MODE_SEARCH, 0, 0, 1, sle_pkg::ST_NOTFOUND, 0, 0);
        add_row(sle_pkg::MODE_DELETE, -1, 1, 1, sle_pkg::ST_EMPTY, 0, 0);
        add_row(sle_pkg::MODE_DELETE, 0, 0, 1, sle_pkg::ST_EMPTY, 0, 0);
        // extremes and a duplicate: list ends up min, 0, 0, max
        add_row(sle_pkg::MODE_INSERT, 32'sh7FFF_FFFF, 31, 1, sle_pkg::ST_INSERTED, 0, 1);
        add_row(sle_pkg::MODE_INSERT, 32'sh8000_0000, 0, 1, sle_pkg::ST_INSERTED, 0, 2);
        add_row(sle_pkg::MODE_INSERT, 0, 0, 1, sle_pkg::ST_INSERTED, 0, 3);
        add_row(sle_pkg::MODE_INSERT, 0, 0, 1, sle_pkg::ST_INSERTED, 0, 4);
        add_row(sle_pkg::MODE_SEARCH, 0, 0, 1, sle_pkg::ST_FOUND, 2, 4);
        add_row(sle_pkg::MODE_SEARCH, 32'sh7FFF_FFFF, 0, 1, sle_pkg::ST_FOUND, 4, 4);
        add_row(sle_pkg::MODE_SEARCH, 5, 0, 1, sle_pkg::ST_NOTFOUND, 0, 4);
        // bad positions: zero, just past the count, all ones
        add_row(sle_pkg::MODE_DELETE, 0, 0, 1, sle_pkg::ST_BADPOS, 0, 4);
        add_row(sle_pkg::MODE_DELETE, 0, 5, 1, sle_pkg::ST_BADPOS, 0, 4);
        add_row(sle_pkg::MODE_DELETE, 0, 31, 1, sle_pkg::ST_BADPOS, 0, 4);
        add_row(sle_pkg::MODE_DELETE, 0, 4, 1, sle_pkg::ST_DELETED, 0, 3);
        // fill to the top, values mixed around both extremes
        for (int k = 0; k < sle_pkg::DEPTH - 3; k++)
            add_row(sle_pkg::MODE_INSERT,
                    k[0] ? val_t'(32'h8000_0000 + k) : val_t'(32'h7FFF_FFFF - k), k, 0);
        add_row(sle_pkg::MODE_INSERT, 1, 0, 1, sle_pkg::ST_FULL, 0, 16);
        add_row(sle_pkg::MODE_SEARCH, 32'sh8000_0000, 0, 1, sle_pkg::ST_FOUND, 1, 16);
        add_row(sle_pkg::MODE_UNUSED, -1, 31, 1, sle_pkg::ST_NOTFOUND, 0, 16);
        add_row(sle_pkg::MODE_DELETE, 0, 16, 1, sle_pkg::ST_DELETED, 0, 15);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (op_table[i])
            send_list_op(op_table[i].op, op_table[i].val, op_table[i].pos,
                         op_table[i].pinned, op_table[i].res);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS - CALM_ITEMS)
                idling_on = 1'b0;
            pick_random_op(op, v, pos);
            send_list_op(op, v, pos, 1'b0, none);
        end
        s_tvalid <= 1'b0;

        // drain, then wait for any stray beat
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (error_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
